// ----- src/block_noise_gate_linear_resampler_unit_macros.svh -----
// Assertion macros used by the resampler datapath.
`ifndef BLOCK_NOISE_GATE_LINEAR_RESAMPLER_UNIT_MACROS_SVH
`define BLOCK_NOISE_GATE_LINEAR_RESAMPLER_UNIT_MACROS_SVH

// Condition implies property in the same cycle.
`define BNGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Condition implies property in the next cycle.
`define BNGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bngr_pkg.sv -----
// Shared types and constants for the block noise gate resampler.
`default_nettype none
package bngr_pkg;

  localparam int BLOCK_MAX = 64;
  localparam int ADDR_W    = $clog2(BLOCK_MAX);
  localparam int CNT_W     = ADDR_W + 1;

  localparam int FLOOR_W = 24;
  localparam int STEP_W  = 20;
  localparam int RATIO_W = 17;
  localparam int WLEN_W  = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_A_W = 2;
  localparam int SUM_W   = 36;
  localparam int POS_W   = 26;

  localparam logic [CFG_A_W-1:0] REG_GATE_FLOOR = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SRC_STEP   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_OUT_RATIO  = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_WINDOW_LEN = 2'd3;

  localparam logic [FLOOR_W-1:0] RST_GATE_FLOOR = 24'd9663;
  localparam logic [STEP_W-1:0]  RST_SRC_STEP   = 20'd142663;
  localparam logic [RATIO_W-1:0] RST_OUT_RATIO  = 17'd30106;
  localparam logic [WLEN_W-1:0]  RST_WINDOW_LEN = 16'd6615;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               end_of_run;
    logic               window_full;
  } out_req_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic setup;
    logic fetch;
    logic mul;
    logic emit;
    logic clear;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic blk_close;
    logic run_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/bngr_ctrl.sv -----
// Sequencer for block collection and output generation.
`default_nettype none
module bngr_ctrl
  import bngr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_SETUP,
    S_ADDR,
    S_MUL,
    S_SUM
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_COLLECT: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && sts.blk_close) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        if (sts.run_done) begin
          cmd.clear = 1'b1;
          state_nxt = S_COLLECT;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // hold until the output register can take the next request
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_ADDR;
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/bngr_dp.sv -----
// Datapath: block store, energy sum, gate decision, interpolator, output register.
`default_nettype none
`include "block_noise_gate_linear_resampler_unit_macros.svh"
module bngr_dp
  import bngr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire in_req_t            in_data,
  output out_req_t                out_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire cmd_t               cmd,
  output sts_t                    sts
);

  logic [FLOOR_W-1:0] floor_r;
  logic [STEP_W-1:0]  step_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [WLEN_W-1:0]  wlen_r;

  logic signed [15:0] mem [BLOCK_MAX];

  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   count_r;
  logic [WLEN_W-1:0]  fill_r;
  logic               gated_r;
  logic [CNT_W-1:0]   len_r;
  logic [CNT_W-1:0]   idx_r;
  logic [POS_W-1:0]   pos_r;
  logic [15:0]        frac_r;
  logic signed [15:0] rd0_r;
  logic signed [15:0] rd1_r;
  logic signed [33:0] p0_r;
  logic signed [33:0] p1_r;
  logic               out_valid_r;
  out_req_t           out_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= RST_GATE_FLOOR;
      step_r  <= RST_SRC_STEP;
      ratio_r <= RST_OUT_RATIO;
      wlen_r  <= RST_WINDOW_LEN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GATE_FLOOR: floor_r <= cfg_wdata[FLOOR_W-1:0];
        REG_SRC_STEP:   step_r  <= cfg_wdata[STEP_W-1:0];
        REG_OUT_RATIO:  ratio_r <= cfg_wdata[RATIO_W-1:0];
        REG_WINDOW_LEN: wlen_r  <= cfg_wdata[WLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // collection
  logic signed [31:0] sq;
  assign sq = 32'(in_data.sample) * 32'(in_data.sample);

  // setup products
  logic [30:0]      gate_prod;
  logic [23:0]      len_prod;
  logic [7:0]       len_raw;
  logic [CNT_W-1:0] len_cap;
  assign gate_prod = 31'(floor_r) * 31'(count_r);
  assign len_prod  = 24'(ratio_r) * 24'(count_r);
  assign len_raw   = len_prod[23:16];
  assign len_cap   = (len_raw > 8'(count_r)) ? count_r : len_raw[CNT_W-1:0];

  // neighbor addresses, clamped to the last stored sample
  logic [9:0]        s0w;
  logic [CNT_W-1:0]  nm1;
  logic [ADDR_W-1:0] s0;
  logic [ADDR_W-1:0] s1;
  assign s0w = pos_r[POS_W-1:16];
  assign nm1 = count_r - 1'b1;
  assign s0  = (s0w > 10'(nm1)) ? nm1[ADDR_W-1:0] : s0w[ADDR_W-1:0];
  assign s1  = (s0 == nm1[ADDR_W-1:0]) ? s0 : s0 + 1'b1;

  // weights
  logic [16:0]        w0;
  logic signed [17:0] w0s;
  logic signed [17:0] w1s;
  assign w0  = 17'h10000 - {1'b0, frac_r};
  assign w0s = $signed({1'b0, w0});
  assign w1s = $signed({2'b00, frac_r});

  // rounding and window flag
  logic signed [34:0] rnd;
  logic [WLEN_W-1:0]  fill_nxt;
  assign rnd      = 35'(p0_r) + 35'(p1_r) + 35'sd32768;
  assign fill_nxt = (fill_r < wlen_r) ? fill_r + 1'b1 : fill_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[count_r[ADDR_W-1:0]] <= in_data.sample;
    end
    if (cmd.fetch) begin
      rd0_r  <= mem[s0];
      rd1_r  <= mem[s1];
      frac_r <= pos_r[15:0];
    end
    if (cmd.mul) begin
      p0_r <= 34'(w0s) * 34'(rd0_r);
      p1_r <= 34'(w1s) * 34'(rd1_r);
    end
    if (cmd.emit) begin
      out_r.out_sample  <= gated_r ? 16'sd0 : rnd[31:16];
      out_r.end_of_run  <= (CNT_W'(idx_r + 1'b1) == len_r);
      out_r.window_full <= (fill_nxt >= wlen_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      gated_r     <= 1'b0;
      len_r       <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        sum_r   <= sum_r + {4'b0000, sq};
        count_r <= count_r + 1'b1;
      end
      if (cmd.setup) begin
        gated_r <= (sum_r < {5'b00000, gate_prod});
        len_r   <= len_cap;
        idx_r   <= '0;
        pos_r   <= '0;
      end
      if (cmd.clear) begin
        sum_r   <= '0;
        count_r <= '0;
      end
      if (cmd.emit) begin
        idx_r  <= idx_r + 1'b1;
        pos_r  <= pos_r + POS_W'(step_r);
        fill_r <= fill_nxt;
      end
      // drop the request once taken, load a new one when emitted
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.blk_close = in_data.last || (count_r == CNT_W'(BLOCK_MAX - 1));
  assign sts.run_done  = (idx_r == len_r);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  `BNGR_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(BLOCK_MAX), "block count overflow")
  `BNGR_ASSERT_NOW(a_fetch_len, cmd.fetch, (len_r <= count_r) && (idx_r < len_r), "bad run index")
  `BNGR_ASSERT_NOW(a_fetch_addr, cmd.fetch, (6'(s0) <= 6'(nm1)) && (6'(s1) <= 6'(nm1)), "read past block")
  `BNGR_ASSERT_NEXT(a_gate_zero, cmd.emit && gated_r, out_r.out_sample == 16'sd0, "gated sample not zero")

endmodule
`default_nettype wire

// ----- src/block_noise_gate_linear_resampler_unit.sv -----
// Top level of the block noise gate with linear-interpolation downsampler.
`default_nettype none
// Collects Q1.15 samples into blocks closed by last (or by the 64th sample),
// storing each block in a 64-entry two-read-port memory while summing the
// squares. When a block of n samples closes, the setup state decides the gate
// (sum of squares below gate_floor_sq * n) and the output count
// min(floor(n * out_ratio / 2^16), n). Each output then passes in turn through
// the shared interpolator: fetch both neighbors from the memory, multiply by
// the Q16 weights, round and load the output register. Samples are loaded at
// one per cycle while collecting, never while a block's outputs are made, and
// output stalls hold the run. Gated blocks emit the same count of zero samples.
// window_full rises once window_len outputs have been delivered and stays
// high (saturating counter). Config writes are taken at any time but are only
// meaningful while the block is idle. The memory needs no clearing after reset.
module block_noise_gate_linear_resampler_unit
  import bngr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_A_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_req_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_req_t                out_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: collect, set up, then fetch/multiply/round per output
  bngr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, arithmetic and the output register
  bngr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

// ----- bench/block_noise_gate_linear_resampler_unit_test.sv -----
// Self-checking testbench for the block noise gate linear resampler unit.
`timescale 1ns / 100ps
module block_noise_gate_linear_resampler_unit_test;
  import bngr_pkg::*;

  // Idle cycles allowed with no request accepted on either channel.
  localparam int STALL_LIMIT = 4000;
  // Quiet time after the last result before touching registers or ending:
  // one full block (64 loads, setup, then fetch, multiply and round per output) with margin.
  localparam int SETTLE_CYCLES = 300;
  // Receiver hold-off used to back the block up into its input.
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 8;

  typedef enum int {STYLE_WIDE, STYLE_QUIET, STYLE_EDGES, STYLE_MIN_RAIL} sample_style_t;

  // Predict the result stream of the gate/resampler and check the block
  // against it in order.
  class resample_predictor;
    logic [FLOOR_W-1:0] floor_sq;
    logic [STEP_W-1:0]  step;
    logic [RATIO_W-1:0] ratio;
    logic [WLEN_W-1:0]  wlen;
    logic signed [15:0] store [BLOCK_MAX];
    logic [SUM_W-1:0]   sum_sq;
    int unsigned        count;
    logic [WLEN_W-1:0]  fill;
    out_req_t           due_outputs[$];
    int                 faults;

    function new();
      floor_sq = RST_GATE_FLOOR;
      step     = RST_SRC_STEP;
      ratio    = RST_OUT_RATIO;
      wlen     = RST_WINDOW_LEN;
      sum_sq   = '0;
      count    = 0;
      fill     = '0;
      faults   = 0;
    endfunction

    function void set_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_GATE_FLOOR: floor_sq = value[FLOOR_W-1:0];
        REG_SRC_STEP:   step     = value[STEP_W-1:0];
        REG_OUT_RATIO:  ratio    = value[RATIO_W-1:0];
        REG_WINDOW_LEN: wlen     = value[WLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_outputs.size();
    endfunction

    // Interpolate output i of the stored block at Q16 position i*step,
    // clamping both neighbors to the last stored sample.
    function logic signed [15:0] lerp_at(int unsigned i);
      longint unsigned pos;
      longint unsigned whole;
      int unsigned     frac;
      int unsigned     s0;
      int unsigned     s1;
      longint          acc;
      pos   = longint'(i) * longint'(step);
      whole = pos >> 16;
      frac  = pos & 64'hFFFF;
      s0    = (whole > count - 1) ? count - 1 : whole;
      s1    = (s0 + 1 > count - 1) ? count - 1 : s0 + 1;
      acc   = longint'(65536 - frac) * longint'(store[s0])
            + longint'(frac) * longint'(store[s1]) + 32768;
      return acc >>> 16;
    endfunction

    // Decide the gate, emit the run of outputs and clear the block.
    function void close_block();
      longint unsigned limit_sq;
      int unsigned     len;
      bit              gated;
      out_req_t        res;
      limit_sq = floor_sq;
      limit_sq = limit_sq * count;
      gated    = (sum_sq < limit_sq);
      len      = (count * ratio) >> 16;
      if (len > count) len = count;
      for (int unsigned i = 0; i < len; i++) begin
        res.out_sample = gated ? 16'sd0 : lerp_at(i);
        res.end_of_run = (i + 1 == len);
        if (fill < wlen) fill++;
        res.window_full = (fill >= wlen);
        due_outputs.insert(due_outputs.size(), res);
      end
      sum_sq = '0;
      count  = 0;
    endfunction

    function void note_sample(in_req_t req);
      longint s;
      s = req.sample;
      store[count] = req.sample;
      sum_sq = sum_sq + s * s;
      count++;
      // A full store closes the block whether or not last is set.
      if (req.last || count >= BLOCK_MAX) close_block();
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (due_outputs.size() == 0) begin
        fault($sformatf("unexpected result sample=%0d end=%0b full=%0b",
                        got.out_sample, got.end_of_run, got.window_full));
        return;
      end
      want = due_outputs.pop_front();
      if (got.out_sample !== want.out_sample || got.end_of_run !== want.end_of_run ||
          got.window_full !== want.window_full)
        fault($sformatf("expected sample=%0d end=%0b full=%0b, got sample=%0d end=%0b full=%0b",
                        want.out_sample, want.end_of_run, want.window_full,
                        got.out_sample, got.end_of_run, got.window_full));
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_req_t            in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_req_t           out_data;

  resample_predictor predictor;

  // Traffic shaping shared between the stimulus and the result drain.
  bit send_calm  = 1'b0;
  bit drain_calm = 1'b0;
  bit hold_req   = 1'b0;
  int sent_in_phase = 0;

  block_noise_gate_linear_resampler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Offer one sample request after a random gap, hold it until accepted,
  // then record it with the predictor. Valid stays high on return.
  task automatic send_sample(input logic signed [15:0] value, input logic last_flag);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data.sample <= value;
    in_data.last   <= last_flag;
    do @(posedge clk); while (in_ready !== 1'b1);
    predictor.note_sample(in_data);
    sent_in_phase++;
  endtask

  function automatic logic signed [15:0] pick_sample(sample_style_t style, int amp);
    int v;
    case (style)
      STYLE_WIDE:     return $urandom;
      STYLE_QUIET: begin
        v = $urandom_range(0, 2 * amp);
        return v - amp;
      end
      STYLE_MIN_RAIL: return -16'sd32768;
      default: begin
        case ($urandom_range(0, 3))
          0:       return -16'sd32768;
          1:       return 16'sd32767;
          2:       return 16'sd0;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  // Send one block of n samples; last goes on the final one when close_it
  // is set (a 64-sample block closes on its own either way).
  task automatic send_block(input int n, input sample_style_t style, input bit close_it);
    int amp;
    case ($urandom_range(0, 4))
      0:       amp = 4;
      1:       amp = 60;
      2:       amp = 200;
      3:       amp = 1000;
      default: amp = 5000;
    endcase
    for (int k = 0; k < n; k++)
      send_sample(pick_sample(style, amp), (k == n - 1) ? close_it : 1'b0);
  endtask

  // Drop valid, drain every expected result, then let the block finish any
  // block that produced no results before going on.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    predictor.set_reg(idx, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Reprogram all four registers once the block is idle.
  task automatic program_regs(input logic [CFG_W-1:0] floor_v, input logic [CFG_W-1:0] step_v,
                              input logic [CFG_W-1:0] ratio_v, input logic [CFG_W-1:0] wlen_v);
    settle();
    write_reg(REG_GATE_FLOOR, floor_v);
    write_reg(REG_SRC_STEP, step_v);
    write_reg(REG_OUT_RATIO, ratio_v);
    write_reg(REG_WINDOW_LEN, wlen_v);
  endtask

  // Result drain: random stalls before each result, calm stretches, and
  // one long hold-off on request so the block backs up into its input.
  initial begin : drain_results
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else if (drain_calm) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      predictor.check_result(out_data);
    end
  end

  // Watchdog: end the run when no request moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("[%0t] timeout: no request accepted for %0d cycles", $realtime, STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] floor_v;
    logic [CFG_W-1:0] step_v;
    logic [CFG_W-1:0] ratio_v;
    logic [CFG_W-1:0] wlen_v;
    int               budget;
    int               pick;
    int               n;
    sample_style_t    style;
    bit               close_it;

    predictor = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values first.
    // Single sample: output count rounds down to zero, block still clears.
    send_sample(16'sd32767, 1'b1);
    // Full-scale rails, one output taken at the first sample.
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b1);
    // Quiet block below the floor: gated to zeros.
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd3, 1'b1);

    // Gate threshold exactly on a square: equal passes, one below gates.
    program_regs(24'd10000, 24'd65536, 24'd65536, 24'd3);
    send_sample(16'sd100, 1'b1);
    send_sample(-16'sd99, 1'b1);

    // Ratio above unity caps at n; huge step clamps positions past the end;
    // gate off and window length zero.
    program_regs(24'd0, 24'hFFFFF, 24'h1FFFF, 24'd0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);

    // Half-step positions: rounding of exact halves, both signs.
    program_regs(24'd0, 24'd32768, 24'd65536, 24'd0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);

    // Zero step and zero ratio: no results at all.
    program_regs(24'd0, 24'd0, 24'd0, 24'd0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd8, 1'b1);

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      send_calm  = 1'b0;
      drain_calm = 1'b0;
      case (ph)
        0: begin
          floor_v = $urandom_range(1, 20000);
          step_v  = RST_SRC_STEP;
          ratio_v = RST_OUT_RATIO;
          wlen_v  = (predictor.fill + 25 > 65535) ? 65535 : predictor.fill + 25;
          budget  = 70;
        end
        1: begin
          floor_v = 24'hFFFFFF;
          step_v  = 24'd65536;
          ratio_v = 24'd65536;
          wlen_v  = 24'd0;
          budget  = 60;
        end
        2: begin
          floor_v = $urandom_range(0, 24'hFFFFFF);
          step_v  = $urandom_range(65536, 20'hFFFFF);
          ratio_v = (64'd1 << 32) / step_v;
          wlen_v  = 24'd65535;
          budget  = 80;
        end
        3: begin
          floor_v = 24'd0;
          step_v  = 24'hFFFFF;
          ratio_v = 24'd1;
          wlen_v  = 24'd1102;
          budget  = 20;
        end
        4: begin
          floor_v = $urandom_range(0, 30000);
          step_v  = $urandom_range(0, 20'hFFFFF);
          ratio_v = $urandom_range(0, 17'h1FFFF);
          wlen_v  = $urandom_range(1102, 44100);
          budget  = 80;
        end
        5: begin
          floor_v = $urandom_range(0, 20000);
          step_v  = $urandom_range(0, 20'hFFFFF);
          ratio_v = 24'd0;
          wlen_v  = $urandom_range(0, 16'hFFFF);
          budget  = 15;
        end
        6: begin
          floor_v = $urandom_range(0, 20000);
          step_v  = RST_SRC_STEP;
          ratio_v = RST_OUT_RATIO;
          wlen_v  = (predictor.fill + 10 > 65535) ? 65535 : predictor.fill + 10;
          budget  = 80;
        end
        default: begin
          floor_v = 24'hFFFFFF;
          step_v  = 24'hFFFFF;
          ratio_v = 24'h1FFFF;
          wlen_v  = 24'd44100;
          budget  = 50;
        end
      endcase
      program_regs(floor_v, step_v, ratio_v, wlen_v);
      sent_in_phase = 0;

      // Back-to-back stretch on both sides.
      if (ph == 1) begin
        send_calm  = 1'b1;
        drain_calm = 1'b1;
      end
      // Stream samples with no gaps while the drain holds off.
      if (ph == 2) begin
        send_calm = 1'b1;
        hold_req  = 1'b1;
      end
      // Full block of negative rails: sum of squares wraps to zero and the
      // block closes on the 64th sample without last.
      if (ph == 0) send_block(BLOCK_MAX, STYLE_MIN_RAIL, 1'b0);

      while (sent_in_phase < budget) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // Loose stream: last lands at random.
          repeat (8) send_sample($urandom, $urandom_range(0, 7) == 0);
        end else begin
          if (pick < 6)      n = $urandom_range(1, 16);
          else if (pick < 9) n = $urandom_range(17, BLOCK_MAX - 1);
          else               n = BLOCK_MAX;
          pick = $urandom_range(0, 19);
          if (pick < 10)      style = STYLE_WIDE;
          else if (pick < 17) style = STYLE_QUIET;
          else                style = STYLE_EDGES;
          close_it = (n < BLOCK_MAX) ? 1'b1 : 1'($urandom_range(0, 1));
          send_block(n, style, close_it);
        end
      end
      // Close any open block so registers only change between blocks.
      if (predictor.count != 0) send_sample($urandom, 1'b1);
    end

    settle();
    if (predictor.faults == 0 && predictor.pending() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/bngr_pkg.sv
src/bngr_ctrl.sv
src/bngr_dp.sv
src/block_noise_gate_linear_resampler_unit.sv
bench/block_noise_gate_linear_resampler_unit_test.sv
